// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the keyed record table.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/krt_pkg.sv =====
// Types and constants of the keyed record table.
// No dependencies; used by keyed_record_table.
package krt_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SEARCH = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_LIST   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

// ===== hdl/keyed_record_table.sv =====
// Keyed record table: packed, unsorted table of up to DEPTH records (32-bit key, PAYLOAD_BITS
// payload) held in one synchronous RAM, walked one entry per clock while no result waits on
// a stalled result port. Search, update and delete stop at the first match or at the end of
// the table; delete then moves later records down; list gives every record in order (one
// result on an empty table). The single RAM read port is why the table is walked entry by
// entry; a stalled result port adds its stall.
// Depends on krt_pkg, krt_ram and assert_macros.svh.
`include "assert_macros.svh"

module keyed_record_table #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [krt_pkg::OP_W-1:0]            i_op,
    input  logic signed [krt_pkg::KEY_W-1:0]    i_key,
    input  logic [krt_pkg::PAY_W-1:0]           i_payload,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [krt_pkg::STATUS_W-1:0]        o_status,
    output logic signed [krt_pkg::KEY_W-1:0]    o_found_key,
    output logic [krt_pkg::PAY_W-1:0]           o_found_payload,
    output logic [krt_pkg::POS_W-1:0]           o_position,
    output logic                                o_last
);

    localparam int KEY_W = krt_pkg::KEY_W;
    localparam int PAY_W = krt_pkg::PAY_W;
    localparam int POS_W = krt_pkg::POS_W;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int WW    = KEY_W + PAYLOAD_BITS;

    krt_pkg::t_state  r_state, n_state;
    krt_pkg::t_op     r_op, n_op;
    logic signed [KEY_W-1:0]   r_key, n_key;
    logic [PAYLOAD_BITS-1:0]   r_pay, n_pay;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;

    logic                      r_out_valid, n_out_valid;
    krt_pkg::t_status          r_status, n_status;
    logic signed [KEY_W-1:0]   r_found_key, n_found_key;
    logic [PAY_W-1:0]          r_found_pay, n_found_pay;
    logic [POS_W-1:0]          r_position, n_position;
    logic                      r_last, n_last;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WW-1:0]    ram_wdata;
    logic [WW-1:0]    ram_rdata;

    logic [KEY_W-1:0]          rd_key;
    logic [PAYLOAD_BITS-1:0]   rd_pay;
    logic             slot_free;
    logic             at_end;
    logic             key_hit;
    logic             idx_last;
    logic [CW-1:0]    idx_next;
    logic [CW-1:0]    idx_prev;

    logic                      emit;
    krt_pkg::t_status          e_status;
    logic [KEY_W-1:0]          e_key;
    logic [PAY_W-1:0]          e_pay;
    logic [POS_W-1:0]          e_pos;

    function automatic logic [CW-1:0] idx_count_inc(input logic [CW-1:0] cnt);
        return cnt + CW'(1);
    endfunction

    krt_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Read data always belongs to r_idx: the address is the next index.
    assign rd_key    = ram_rdata[WW-1 -: KEY_W];
    assign rd_pay    = ram_rdata[PAYLOAD_BITS-1:0];
    assign slot_free = !r_out_valid || i_out_ready;
    assign at_end    = (r_idx == r_count);
    assign key_hit   = (rd_key == r_key);
    assign idx_next  = r_idx + CW'(1);
    assign idx_prev  = r_idx - CW'(1);
    assign idx_last  = (idx_next == r_count);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_pay       = r_pay;
        n_count     = r_count;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = ram_rdata;
        emit        = 1'b0;
        e_status    = krt_pkg::STAT_OK;
        e_key       = '0;
        e_pay       = '0;
        e_pos       = '0;

        unique case (r_state)
            krt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_idx      = '0;
                if (i_in_valid) begin
                    n_op  = krt_pkg::t_op'(i_op);
                    n_key = i_key;
                    n_pay = i_payload[PAYLOAD_BITS-1:0];
                    unique case (krt_pkg::t_op'(i_op)) inside
                        krt_pkg::OP_ADD: n_state = krt_pkg::S_ADD;
                        krt_pkg::OP_SEARCH, krt_pkg::OP_UPDATE,
                        krt_pkg::OP_DELETE, krt_pkg::OP_LIST: n_state = krt_pkg::S_SCAN;
                        default: n_state = krt_pkg::S_IDLE;
                    endcase
                end
            end

            krt_pkg::S_ADD: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = krt_pkg::S_IDLE;
                    if (r_count == CW'(DEPTH)) begin
                        e_status = krt_pkg::STAT_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = {r_key, r_pay};
                        e_key     = r_key;
                        e_pay     = PAY_W'(r_pay);
                        e_pos     = POS_W'(r_count);
                        n_count   = idx_count_inc(r_count);
                    end
                end
            end

            krt_pkg::S_SCAN: begin
                if (r_op == krt_pkg::OP_LIST) begin
                    if (r_count == '0) begin
                        if (slot_free) begin
                            emit     = 1'b1;
                            e_status = krt_pkg::STAT_EMPTY;
                            n_state  = krt_pkg::S_IDLE;
                        end
                    end else if (slot_free) begin
                        emit  = 1'b1;
                        e_key = rd_key;
                        e_pay = PAY_W'(rd_pay);
                        e_pos = POS_W'(r_idx);
                        if (idx_last) begin
                            n_state = krt_pkg::S_IDLE;
                        end else begin
                            n_idx = idx_next;
                        end
                    end
                end else if (at_end) begin
                    if (slot_free) begin
                        emit     = 1'b1;
                        e_status = krt_pkg::STAT_NOT_FOUND;
                        n_state  = krt_pkg::S_IDLE;
                    end
                end else if (key_hit) begin
                    if (slot_free) begin
                        emit  = 1'b1;
                        e_key = rd_key;
                        e_pay = PAY_W'(rd_pay);
                        e_pos = POS_W'(r_idx);
                        if (r_op == krt_pkg::OP_UPDATE) begin
                            ram_we    = 1'b1;
                            ram_wdata = {rd_key, r_pay};
                            e_pay     = PAY_W'(r_pay);
                        end
                        if (r_op == krt_pkg::OP_DELETE) begin
                            n_state = krt_pkg::S_SHIFT;
                            n_idx   = idx_next;
                        end else begin
                            n_state = krt_pkg::S_IDLE;
                        end
                    end
                end else begin
                    n_idx = idx_next;
                end
            end

            krt_pkg::S_SHIFT: begin
                // Move the record at r_idx down one place until the end of the table.
                if (at_end) begin
                    n_count = r_count - CW'(1);
                    n_state = krt_pkg::S_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_prev[AW-1:0];
                    n_idx     = idx_next;
                end
            end

            default: n_state = krt_pkg::S_IDLE;
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_found_key = r_found_key;
        n_found_pay = r_found_pay;
        n_position  = r_position;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_status    = e_status;
            n_found_key = e_key;
            n_found_pay = e_pay;
            n_position  = e_pos;
            // Only a list item gives more than one result.
            n_last      = (r_state != krt_pkg::S_SCAN) || (r_op != krt_pkg::OP_LIST) ||
                          (r_count == '0) || idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krt_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_pay       <= n_pay;
        r_status    <= n_status;
        r_found_key <= n_found_key;
        r_found_pay <= n_found_pay;
        r_position  <= n_position;
        r_last      <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_key     = r_found_key;
    assign o_found_payload = r_found_pay;
    assign o_position      = r_position;
    assign o_last          = r_last;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH), "entry count above depth")
    `ASSERT_NEVER(a_scan_bound, i_clk, i_rst_n, (r_state == krt_pkg::S_SCAN) && (r_idx > r_count), "scan index past table end")
    `ASSERT_NEVER(a_shift_bound, i_clk, i_rst_n, (r_state == krt_pkg::S_SHIFT) && ((r_idx == '0) || (r_idx > r_count)), "shift index out of range")
    `ASSERT_SYNC(a_add_count, i_clk, i_rst_n, (r_state == krt_pkg::S_ADD) && slot_free && (r_count != CW'(DEPTH)) |=> (r_count == $past(r_count) + CW'(1)), "add did not grow the table")
    `ASSERT_SYNC(a_del_count, i_clk, i_rst_n, (r_state == krt_pkg::S_SHIFT) && at_end |=> (r_count == $past(r_count) - CW'(1)), "delete did not shrink the table")

endmodule

// ===== hdl/krt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module krt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
